[rtl/tlbfl_pkg.sv]
// Shared types and op codes for the free-list translation buffer.
package tlbfl_pkg;

  typedef enum logic [2:0] {
    OP_LOOKUP_V   = 3'd0,
    OP_LOOKUP_P   = 3'd1,
    OP_ADD        = 3'd2,
    OP_FLUSH_ALL  = 3'd3,
    OP_FLUSH_ONE  = 3'd4,
    OP_FLUSH_RANGE = 3'd5,
    OP_NOP        = 3'd6
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [3:0]  prot;
    logic [31:0] range_end;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

  typedef enum logic {
    BK_MATCH = 1'b0,
    BK_DONE  = 1'b1
  } bk_state_t;

endpackage

[rtl/tlbfl_front.sv]
// Front end: decodes incoming commands and holds them in a two-deep queue.
module tlbfl_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           in_op,
  input  logic [31:0]          in_virt_addr,
  input  logic [31:0]          in_phys_addr,
  input  logic [3:0]           in_prot,
  input  logic [31:0]          in_range_end,
  output tlbfl_pkg::qhead_t    qhead,
  input  logic                 pop
);

  tlbfl_pkg::cmd_t q_r [2];
  logic            wp_r, wp_nxt;
  logic            rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push;
  tlbfl_pkg::cmd_t cmd;
  tlbfl_pkg::op_t  op_dec;

  always_comb begin
    unique case (in_op)
      3'd0:    op_dec = tlbfl_pkg::OP_LOOKUP_V;
      3'd1:    op_dec = tlbfl_pkg::OP_LOOKUP_P;
      3'd2:    op_dec = tlbfl_pkg::OP_ADD;
      3'd3:    op_dec = tlbfl_pkg::OP_FLUSH_ALL;
      3'd4:    op_dec = tlbfl_pkg::OP_FLUSH_ONE;
      3'd5:    op_dec = tlbfl_pkg::OP_FLUSH_RANGE;
      default: op_dec = tlbfl_pkg::OP_NOP;
    endcase
  end

  assign cmd.op        = op_dec;
  assign cmd.virt_addr = in_virt_addr;
  assign cmd.phys_addr = in_phys_addr;
  assign cmd.prot      = in_prot;
  assign cmd.range_end = in_range_end;

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy;

  assign qhead.valid = (cnt_r != 2'd0);
  assign qhead.cmd   = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cmd;
    end
  end

endmodule

[rtl/tlbfl_back.sv]
// Back end: entry array, associative match, free list head and victim pointer.
module tlbfl_back #(
  parameter int ENTRIES   = 64,
  parameter int PAGE_BITS = 12,
  parameter int ADDR_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tlbfl_pkg::qhead_t qhead,
  output logic              pop,
  output logic              out_valid,
  output logic              out_hit,
  output logic [31:0]       out_found_addr,
  output logic [3:0]        out_found_prot,
  output logic [5:0]        out_slot
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LW = $clog2(ENTRIES + 1);
  localparam int FW = ADDR_BITS - PAGE_BITS;
  localparam logic [LW-1:0] LINK_END = LW'(ENTRIES);

  logic [FW-1:0]      vfr_r [ENTRIES];
  logic [FW-1:0]      pfr_r [ENTRIES];
  logic [3:0]         prot_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [LW-1:0]      head_r, head_nxt;
  logic [IW-1:0]      victim_r, victim_nxt;

  tlbfl_pkg::bk_state_t state_r, state_nxt;
  tlbfl_pkg::cmd_t      cmd_r;
  logic                 hit_r;
  logic [IW-1:0]        hit_idx_r;
  logic [ENTRIES-1:0]   drop_r;

  logic                 do_match, do_done;
  logic [FW-1:0]        cvf, cpf, cef;
  logic [ENTRIES-1:0]   eq_v, eq_p, in_rng, sel, drop_c;
  logic [IW-1:0]        lo_idx;

  logic                 list_free, add_new, write_en;
  logic [IW-1:0]        add_idx;
  logic [ENTRIES-1:0]   add_bit, valid_add;
  logic [IW-1:0]        hi_free, hi_drop;

  logic                 res_hit;
  logic [31:0]          res_addr;
  logic [3:0]           res_prot;
  logic [5:0]           res_slot;
  logic [FW-1:0]        rd_frame;

  function automatic logic [FW-1:0] frame_of(input logic [31:0] a);
    logic [ADDR_BITS-1:0] e;
    e = ADDR_BITS'(a);
    return e[ADDR_BITS-1:PAGE_BITS];
  endfunction

  function automatic logic [IW-1:0] inc_wrap(input logic [IW-1:0] v);
    return (v == IW'(ENTRIES - 1)) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [IW-1:0] highest(input logic [ENTRIES-1:0] v);
    logic [IW-1:0] h;
    h = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (v[i]) h = IW'(i);
    end
    return h;
  endfunction

  // FSM: a match state, then an update state that posts the result
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlbfl_pkg::BK_MATCH: if (qhead.valid) state_nxt = tlbfl_pkg::BK_DONE;
      tlbfl_pkg::BK_DONE:  state_nxt = tlbfl_pkg::BK_MATCH;
      default:             state_nxt = tlbfl_pkg::BK_MATCH;
    endcase
  end

  always_comb begin
    do_match = 1'b0;
    do_done  = 1'b0;
    unique case (state_r)
      tlbfl_pkg::BK_MATCH: do_match = qhead.valid;
      tlbfl_pkg::BK_DONE:  do_done  = 1'b1;
      default: ;
    endcase
  end

  assign pop = do_match;

  // associative compare against the queued command
  assign cvf = frame_of(qhead.cmd.virt_addr);
  assign cpf = frame_of(qhead.cmd.phys_addr);
  assign cef = frame_of(qhead.cmd.range_end);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      eq_v[i]   = valid_r[i] && (vfr_r[i] == cvf);
      eq_p[i]   = valid_r[i] && (pfr_r[i] == cpf);
      in_rng[i] = valid_r[i] && (vfr_r[i] >= cvf) && (vfr_r[i] < cef);
    end
    sel = (qhead.cmd.op == tlbfl_pkg::OP_LOOKUP_P) ? eq_p : eq_v;
    lo_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (sel[i]) lo_idx = IW'(i);
    end
    case (qhead.cmd.op)
      tlbfl_pkg::OP_FLUSH_ONE:   drop_c = eq_v;
      tlbfl_pkg::OP_FLUSH_RANGE: drop_c = in_rng;
      default:                   drop_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_match) begin
      cmd_r     <= qhead.cmd;
      hit_r     <= |sel;
      hit_idx_r <= lo_idx;
      drop_r    <= drop_c;
    end
  end

  // update stage
  assign list_free = (head_r != LINK_END);
  assign add_idx   = list_free ? head_r[IW-1:0] : victim_r;
  assign add_new   = (cmd_r.op == tlbfl_pkg::OP_ADD) && !hit_r;
  assign write_en  = do_done && add_new;
  assign add_bit   = ENTRIES'(1) << add_idx;
  assign valid_add = valid_r | add_bit;
  assign hi_free   = highest(~valid_add);
  assign hi_drop   = highest(drop_r);
  assign rd_frame  = (cmd_r.op == tlbfl_pkg::OP_LOOKUP_P) ? vfr_r[hit_idx_r] : pfr_r[hit_idx_r];

  always_comb begin
    valid_nxt  = valid_r;
    head_nxt   = head_r;
    victim_nxt = victim_r;
    res_hit    = 1'b0;
    res_addr   = '0;
    res_prot   = '0;
    res_slot   = '0;
    if (do_done) begin
      case (cmd_r.op)
        tlbfl_pkg::OP_LOOKUP_V, tlbfl_pkg::OP_LOOKUP_P, tlbfl_pkg::OP_ADD: begin
          if (hit_r) begin
            res_hit  = 1'b1;
            res_addr = 32'({rd_frame, {PAGE_BITS{1'b0}}});
            res_prot = prot_r[hit_idx_r];
            res_slot = 6'(hit_idx_r);
          end else if (add_new) begin
            res_slot   = 6'(add_idx);
            valid_nxt  = valid_add;
            head_nxt   = (&valid_add) ? LINK_END : LW'(hi_free);
            victim_nxt = list_free ? inc_wrap(victim_r) : inc_wrap(inc_wrap(victim_r));
          end
        end
        tlbfl_pkg::OP_FLUSH_ALL: begin
          valid_nxt = '0;
          head_nxt  = LW'(ENTRIES - 1);
        end
        tlbfl_pkg::OP_FLUSH_ONE, tlbfl_pkg::OP_FLUSH_RANGE: begin
          valid_nxt = valid_r & ~drop_r;
          // latest dropped entry with the highest index ends up on top
          if (|drop_r) head_nxt = LW'(hi_drop);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tlbfl_pkg::BK_MATCH;
      valid_r   <= '0;
      head_r    <= LW'(ENTRIES - 1);
      victim_r  <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      head_r    <= head_nxt;
      victim_r  <= victim_nxt;
      out_valid <= do_done;
    end
  end

  always_ff @(posedge clk) begin
    if (do_done) begin
      out_hit        <= res_hit;
      out_found_addr <= res_addr;
      out_found_prot <= res_prot;
      out_slot       <= res_slot;
    end
    if (write_en) begin
      vfr_r[add_idx]  <= frame_of(cmd_r.virt_addr);
      pfr_r[add_idx]  <= frame_of(cmd_r.phys_addr);
      prot_r[add_idx] <= cmd_r.prot;
    end
  end

endmodule

[rtl/tlb_free_list_round_robin.sv]
// Fully associative translation buffer with LIFO free list and round-robin victim.
//
// Commands enter on start/in_* when busy is low; a two-deep queue sits in
// front of the execution stage, so busy rises only when both slots are taken.
// Every command (lookup virtual, lookup physical, add, flush all, flush one,
// flush range, and unused codes) gives exactly one result, shown on out_*
// for one cycle with out_valid high.
// The execution stage works on one command at a time: a match step for the
// parallel compare over all entries, then an update step for the entry, the
// free list head and the victim pointer, with the result registered onto out_*.
// The queue can take new commands while a command is being executed.
// The receiver cannot stall: results are never held back.
// Reset (rst_n low, synchronous) invalidates all entries, empties the queue,
// puts the free list head at the top entry and the victim pointer at zero.
// Entry contents are not cleared; invalid entries are never matched.
module tlb_free_list_round_robin #(
  parameter int ENTRIES   = 64,
  parameter int PAGE_BITS = 12,
  parameter int ADDR_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_virt_addr,
  input  logic [31:0] in_phys_addr,
  input  logic [3:0]  in_prot,
  input  logic [31:0] in_range_end,
  output logic        out_valid,
  output logic        out_hit,
  output logic [31:0] out_found_addr,
  output logic [3:0]  out_found_prot,
  output logic [5:0]  out_slot
);

  tlbfl_pkg::qhead_t qhead;
  logic              pop;

  tlbfl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_virt_addr (in_virt_addr),
    .in_phys_addr (in_phys_addr),
    .in_prot      (in_prot),
    .in_range_end (in_range_end),
    .qhead        (qhead),
    .pop          (pop)
  );

  tlbfl_back #(
    .ENTRIES   (ENTRIES),
    .PAGE_BITS (PAGE_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .qhead          (qhead),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_found_addr (out_found_addr),
    .out_found_prot (out_found_prot),
    .out_slot       (out_slot)
  );

endmodule

[rtl/tlbfl_checker.sv]
// Port-level assertions for the translation buffer, bound to the top level.
module tlbfl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_hit,
  input logic [31:0] out_found_addr,
  input logic [3:0]  out_found_prot
);

  // execution passes through a match state and an update state, so result strobes never come back to back
  a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes in consecutive cycles");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_found_addr == '0 && out_found_prot == '0))
    else $error("miss result carries nonzero data");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // an idle block that is offered no transaction does not become busy in the next cycle
  a_busy_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start) |=> !busy)
    else $error("busy rose without a new transaction");

endmodule

bind tlb_free_list_round_robin tlbfl_checker u_tlbfl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_hit        (out_hit),
  .out_found_addr (out_found_addr),
  .out_found_prot (out_found_prot)
);

[test/tlb_free_list_round_robin_tb.sv]
// Self-checking testbench for the free-list translation buffer: directed table, then random ops.
module tlb_free_list_round_robin_tb;

  localparam int NSLOT = 64;
  localparam logic [6:0] CHAIN_END = 7'd64;
  localparam logic [2:0] OP_UNUSED7 = 3'd7;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic        hit;
    logic [31:0] addr;
    logic [3:0]  prot;
    logic [5:0]  slot;
  } xlat_res_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] va;
    logic [31:0] pa;
    logic [3:0]  pr;
    logic [31:0] re;
    bit          typed;
    xlat_res_t   res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0]  in_op = tlbfl_pkg::OP_LOOKUP_V;
  logic [31:0] in_virt_addr = '0;
  logic [31:0] in_phys_addr = '0;
  logic [3:0]  in_prot = '0;
  logic [31:0] in_range_end = '0;
  logic out_valid, out_hit;
  logic [31:0] out_found_addr;
  logic [3:0]  out_found_prot;
  logic [5:0]  out_slot;

  // typed expectation travels with the transaction
  bit        row_typed = 1'b0;
  xlat_res_t row_res = '{1'b0, 32'd0, 4'd0, 6'd0};

  tlb_free_list_round_robin dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the translation buffer
  bit         sh_valid [NSLOT];
  logic [19:0] sh_vf   [NSLOT];
  logic [19:0] sh_pf   [NSLOT];
  logic [3:0]  sh_prot [NSLOT];
  logic [6:0]  sh_link [NSLOT];
  logic [6:0]  sh_head;
  logic [5:0]  sh_victim;

  xlat_res_t pending[$];
  int errors = 0;
  int n_in = 0, n_out = 0, n_hit = 0;

  function automatic void relink_free();
    sh_head = CHAIN_END;
    for (int i = 0; i < NSLOT; i++)
      if (!sh_valid[i]) begin
        sh_link[i] = sh_head;
        sh_head = 7'(i);
      end
  endfunction

  function automatic void evict(int i);
    if (!sh_valid[i]) return;
    sh_link[i] = sh_head;
    sh_head = 7'(i);
    sh_valid[i] = 1'b0;
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < NSLOT; i++) begin
      sh_valid[i] = 1'b0;
      sh_vf[i] = '0;
      sh_pf[i] = '0;
      sh_prot[i] = '0;
    end
    relink_free();
    sh_victim = '0;
  endfunction

  function automatic xlat_res_t translate(logic [2:0] op, logic [31:0] va, logic [31:0] pa,
                                          logic [3:0] pr, logic [31:0] re);
    xlat_res_t r;
    logic [19:0] vf, pf, ef;
    int idx;
    r = '{1'b0, 32'd0, 4'd0, 6'd0};
    vf = va[31:12];
    pf = pa[31:12];
    ef = re[31:12];
    case (op)
      tlbfl_pkg::OP_LOOKUP_V, tlbfl_pkg::OP_LOOKUP_P: begin
        for (int i = 0; i < NSLOT; i++)
          if (sh_valid[i] && (op == tlbfl_pkg::OP_LOOKUP_V ? sh_vf[i] == vf
                                                           : sh_pf[i] == pf)) begin
            r = '{1'b1, {(op == tlbfl_pkg::OP_LOOKUP_V ? sh_pf[i] : sh_vf[i]), 12'd0},
                  sh_prot[i], 6'(i)};
            break;
          end
      end
      tlbfl_pkg::OP_ADD: begin
        for (int i = 0; i < NSLOT; i++)
          if (sh_valid[i] && sh_vf[i] == vf) begin
            r = '{1'b1, {sh_pf[i], 12'd0}, sh_prot[i], 6'(i)};
            return r;
          end
        idx = sh_head;
        if (idx >= NSLOT) begin
          idx = sh_victim;
          sh_victim = 6'(idx + 1);
        end
        sh_victim = sh_victim + 6'd1;
        evict(idx);
        sh_vf[idx] = vf;
        sh_pf[idx] = pf;
        sh_prot[idx] = pr;
        sh_valid[idx] = 1'b1;
        sh_head = sh_link[idx];
        sh_link[idx] = CHAIN_END;
        if (idx != sh_head) relink_free();
        r.slot = 6'(idx);
      end
      tlbfl_pkg::OP_FLUSH_ALL: begin
        for (int i = 0; i < NSLOT; i++) evict(i);
        relink_free();
      end
      tlbfl_pkg::OP_FLUSH_ONE: begin
        for (int i = 0; i < NSLOT; i++)
          if (sh_valid[i] && sh_vf[i] == vf) evict(i);
      end
      tlbfl_pkg::OP_FLUSH_RANGE: begin
        for (int i = 0; i < NSLOT; i++)
          if (sh_valid[i] && sh_vf[i] >= vf && sh_vf[i] < ef) evict(i);
      end
      default: ;
    endcase
    return r;
  endfunction

  int quiet = 0;

  always @(posedge clk) begin
    xlat_res_t p, e;
    if (rst_n) begin
      quiet++;
      if (start && !busy) begin
        p = translate(in_op, in_virt_addr, in_phys_addr, in_prot, in_range_end);
        pending.push_back(row_typed ? row_res : p);
        n_in++;
        quiet = 0;
      end
      if (out_valid) begin
        quiet = 0;
        n_out++;
        if (pending.size() == 0) begin
          $error("result with no transaction outstanding");
          errors++;
        end else begin
          e = pending.pop_front();
          if (out_hit) n_hit++;
          if (out_hit !== e.hit) begin
            $error("hit: expected %0h, got %0h", e.hit, out_hit); errors++;
          end
          if (out_found_addr !== e.addr) begin
            $error("found_addr: expected %h, got %h", e.addr, out_found_addr); errors++;
          end
          if (out_found_prot !== e.prot) begin
            $error("found_prot: expected %h, got %h", e.prot, out_found_prot); errors++;
          end
          if (out_slot !== e.slot) begin
            $error("slot: expected %0d, got %0d", e.slot, out_slot); errors++;
          end
        end
      end
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no progress, %0d results outstanding", pending.size());
        $display("tlb_free_list_round_robin_tb: errors");
        $finish;
      end
    end
  end

  task automatic issue(row_t r, int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_op <= r.op;
    in_virt_addr <= r.va;
    in_phys_addr <= r.pa;
    in_prot <= r.pr;
    in_range_end <= r.re;
    row_typed <= r.typed;
    row_res <= r.res;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(9))
      0, 1: return $urandom();
      default: return {12'h000, $urandom_range(95) == 0 ? 8'hFF : 8'($urandom_range(95)),
                       12'($urandom())};
    endcase
  endfunction

  function automatic row_t rand_row();
    row_t r;
    int k;
    k = $urandom_range(99);
    r.op = k < 40 ? tlbfl_pkg::OP_ADD : k < 60 ? tlbfl_pkg::OP_LOOKUP_V :
           k < 75 ? tlbfl_pkg::OP_LOOKUP_P : k < 85 ? tlbfl_pkg::OP_FLUSH_ONE :
           k < 93 ? tlbfl_pkg::OP_FLUSH_RANGE : k < 95 ? tlbfl_pkg::OP_FLUSH_ALL :
           k < 97 ? tlbfl_pkg::OP_NOP : OP_UNUSED7;
    r.va = pick_addr();
    r.pa = pick_addr();
    r.pr = 4'($urandom());
    r.re = $urandom_range(9) == 0 ? $urandom() : r.va + ($urandom_range(20) << 12);
    r.typed = 1'b0;
    r.res = '{1'b0, 32'd0, 4'd0, 6'd0};
    return r;
  endfunction

  row_t dir_rows[$];
  localparam xlat_res_t Z = '{1'b0, 32'd0, 4'd0, 6'd0};

  initial begin
    shadow_reset();
    dir_rows = '{
      '{tlbfl_pkg::OP_LOOKUP_V,    32'h0000_0000, 32'h0, 4'h0, 32'h0, 1, Z},
      '{tlbfl_pkg::OP_LOOKUP_P,    32'h0,  32'hFFFF_FFFF, 4'h0, 32'h0, 1, Z},
      '{tlbfl_pkg::OP_ADD,         32'h0000_0000, 32'h0000_0000, 4'hF, 32'h0, 1,
        '{1'b0, 32'd0, 4'd0, 6'd63}},
      '{tlbfl_pkg::OP_ADD,         32'h0000_0ABC, 32'h1234_5000, 4'h3, 32'h0, 1,
        '{1'b1, 32'd0, 4'hF, 6'd63}},
      '{tlbfl_pkg::OP_ADD,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0, 32'h0, 1,
        '{1'b0, 32'd0, 4'd0, 6'd62}},
      '{tlbfl_pkg::OP_LOOKUP_V,    32'hFFFF_F123, 32'h0, 4'h0, 32'h0, 1,
        '{1'b1, 32'hFFFF_F000, 4'h0, 6'd62}},
      '{tlbfl_pkg::OP_LOOKUP_P,    32'h0, 32'h0000_0FFF, 4'h0, 32'h0, 1,
        '{1'b1, 32'h0, 4'hF, 6'd63}},
      '{tlbfl_pkg::OP_ADD,         32'h5555_5000, 32'hAAAA_A000, 4'h5, 32'h0, 0, Z},
      '{tlbfl_pkg::OP_ADD,         32'hAAAA_A000, 32'h5555_5000, 4'hA, 32'h0, 0, Z},
      '{tlbfl_pkg::OP_LOOKUP_P,    32'h0, 32'h5555_5FFF, 4'h0, 32'h0, 0, Z},
      '{tlbfl_pkg::OP_FLUSH_ONE,   32'h0000_0FFF, 32'h0, 4'h0, 32'h0, 1, Z},
      '{tlbfl_pkg::OP_LOOKUP_V,    32'h0000_0000, 32'h0, 4'h0, 32'h0, 1, Z},
      '{tlbfl_pkg::OP_ADD,         32'h0000_1000, 32'h0000_2000, 4'h9, 32'h0, 0, Z},
      '{tlbfl_pkg::OP_FLUSH_RANGE, 32'hAAAA_A000, 32'h0, 4'h0, 32'h5555_5000, 1, Z},
      '{tlbfl_pkg::OP_FLUSH_RANGE, 32'h5555_5000, 32'h0, 4'h0, 32'h5555_5FFF, 1, Z},
      '{tlbfl_pkg::OP_LOOKUP_V,    32'h5555_5000, 32'h0, 4'h0, 32'h0, 0, Z},
      '{tlbfl_pkg::OP_FLUSH_RANGE, 32'h0000_0000, 32'h0, 4'h0, 32'hFFFF_FFFF, 1, Z},
      '{tlbfl_pkg::OP_LOOKUP_V,    32'hFFFF_F000, 32'h0, 4'h0, 32'h0, 0, Z},
      '{tlbfl_pkg::OP_NOP,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 1, Z},
      '{OP_UNUSED7,                32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 1, Z},
      '{tlbfl_pkg::OP_FLUSH_ALL,   32'h0, 32'h0, 4'h0, 32'h0, 1, Z},
      '{tlbfl_pkg::OP_LOOKUP_P,    32'h0, 32'h0000_2000, 4'h0, 32'h0, 1, Z},
      '{tlbfl_pkg::OP_ADD,         32'h0000_3000, 32'h0000_4000, 4'h1, 32'h0, 1,
        '{1'b0, 32'd0, 4'd0, 6'd63}}
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) issue(dir_rows[i], 19);
    for (int ph = 0; ph < 3; ph++)
      for (int n = 0; n < 650; n++)
        issue(rand_row(), ph == 0 ? 19 : ph == 1 ? 84 : 0);
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d commands, %0d results, %0d hits, over three idle profiles",
             n_in, n_out, n_hit);
    if (errors == 0 && pending.size() == 0)
      $display("tlb_free_list_round_robin_tb: clean");
    else
      $display("tlb_free_list_round_robin_tb: errors");
    $finish;
  end
endmodule

[sim.f]
rtl/tlbfl_pkg.sv
rtl/tlbfl_front.sv
rtl/tlbfl_back.sv
rtl/tlb_free_list_round_robin.sv
rtl/tlbfl_checker.sv
test/tlb_free_list_round_robin_tb.sv
